>>> design/trht_pkg.sv
// shared types and constants for the topmost rectangle hit test
package trht_pkg;

  localparam int MAX_NODES_DEF   = 256;
  localparam int ACTIVE_NODES_W  = 9;
  localparam int NODE_INDEX_W    = 8;
  localparam int COORD_W         = 16;
  localparam int Z_W             = 16;
  localparam int RECT_W          = 4 * COORD_W;
  localparam int ATTR_W          = Z_W + 1;
  localparam int IN_DATA_W       = 128;
  localparam int IN_USER_W       = 1;
  localparam int OUT_DATA_W      = 8;
  localparam int OUT_USER_W      = 1;
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int CMD_PTR_W       = 1;
  localparam int CMD_CNT_W       = 2;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    action_t                  action;
    logic [NODE_INDEX_W-1:0]  node_index;
    logic [COORD_W-1:0]       rect_x;
    logic [COORD_W-1:0]       rect_y;
    logic [COORD_W-1:0]       rect_w;
    logic [COORD_W-1:0]       rect_h;
    logic signed [Z_W-1:0]    z_level;
    logic                     can_focus;
    logic [COORD_W-1:0]       point_x;
    logic [COORD_W-1:0]       point_y;
  } cmd_t;

endpackage

>>> design/trht_front.sv
// input stage: unpacks stream items, drops out-of-range writes, feeds the command queue
module trht_front #(
  parameter int MAX_NODES = trht_pkg::MAX_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [trht_pkg::IN_DATA_W-1:0] s_data,
  input  logic [trht_pkg::IN_USER_W-1:0] s_user,
  output logic                          q_push,
  input  logic                          q_ready,
  output trht_pkg::cmd_t                q_cmd
);
  import trht_pkg::*;

  cmd_t in_cmd;
  cmd_t hold_cmd;
  logic hold_valid;
  logic keep;
  logic accept;

  always_comb begin
    in_cmd            = '0;
    in_cmd.action     = action_t'(s_user[0]);
    in_cmd.node_index = s_data[7:0];
    in_cmd.rect_x     = s_data[23:8];
    in_cmd.rect_y     = s_data[39:24];
    in_cmd.rect_w     = s_data[55:40];
    in_cmd.rect_h     = s_data[71:56];
    in_cmd.z_level    = s_data[87:72];
    in_cmd.can_focus  = s_data[88];
    in_cmd.point_x    = s_data[104:89];
    in_cmd.point_y    = s_data[120:105];
  end

  // writes past the table end do nothing
  assign keep    = (in_cmd.action == ACT_QUERY) || (int'(in_cmd.node_index) < MAX_NODES);
  assign s_ready = !hold_valid || q_ready;
  assign accept  = s_valid && s_ready;
  assign q_push  = hold_valid;
  assign q_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (q_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd <= in_cmd;
    end
  end

endmodule

>>> design/trht_cmd_fifo.sv
// short command queue between the input stage and the scan engine
module trht_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  trht_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_pop,
  output trht_pkg::cmd_t out_cmd
);
  import trht_pkg::*;

  cmd_t                 slots [CMD_QUEUE_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign in_ready  = (count != CMD_CNT_W'(CMD_QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

>>> design/trht_back.sv
// scan engine: node tables, entry writes and the z-priority scan for queries
module trht_back #(
  parameter int MAX_NODES = trht_pkg::MAX_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [trht_pkg::ACTIVE_NODES_W-1:0] active_nodes,
  input  logic                                cmd_valid,
  input  trht_pkg::cmd_t                      cmd,
  output logic                                cmd_pop,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                res_found,
  output logic [trht_pkg::OUT_DATA_W-1:0]     res_node
);
  import trht_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  logic [RECT_W-1:0] rect_store [MAX_NODES];
  logic [ATTR_W-1:0] attr_store [MAX_NODES];

  logic [ACTIVE_NODES_W-1:0] scan_cnt;
  logic [ACTIVE_NODES_W-1:0] scan_limit;
  logic [ACTIVE_NODES_W-1:0] limit_next;
  logic [ACTIVE_NODES_W-1:0] rd_idx;
  logic [ACTIVE_NODES_W-1:0] cmp_idx;
  logic [ACTIVE_NODES_W-1:0] best_idx;
  logic [COORD_W-1:0]      px;
  logic [COORD_W-1:0]      py;
  logic [RECT_W-1:0]       rd_rect;
  logic [ATTR_W-1:0]       rd_attr;
  logic                    rd_valid;
  logic                    cmp_valid;
  logic                    cmp_hit;
  logic signed [Z_W-1:0]   cmp_z;
  logic signed [Z_W-1:0]   best_z;
  logic                    found;
  logic                    take_write;
  logic                    take_query;
  logic                    rd_en;
  logic                    scan_done;
  logic                    in_x;
  logic                    in_y;
  logic [COORD_W-1:0]      rx;
  logic [COORD_W-1:0]      ry;
  logic [COORD_W-1:0]      rw;
  logic [COORD_W-1:0]      rh;

  assign take_write = cmd_valid && (state == ST_IDLE) && (cmd.action == ACT_WRITE);
  assign take_query = cmd_valid && (state == ST_IDLE) && (cmd.action == ACT_QUERY) && !res_valid;
  assign cmd_pop    = take_write || take_query;
  assign rd_en      = (state == ST_SCAN) && (scan_cnt != scan_limit);
  assign scan_done  = (state == ST_SCAN) && (scan_cnt == scan_limit) && !rd_valid && !cmp_valid;

  always_comb begin
    if (int'(active_nodes) > MAX_NODES) begin
      limit_next = ACTIVE_NODES_W'(MAX_NODES);
    end else begin
      limit_next = active_nodes;
    end
  end

  // rectangle ends carry into a 17th bit, so no wrap
  assign rx   = rd_rect[15:0];
  assign ry   = rd_rect[31:16];
  assign rw   = rd_rect[47:32];
  assign rh   = rd_rect[63:48];
  assign in_x = (px >= rx) && ({1'b0, px} < ({1'b0, rx} + {1'b0, rw}));
  assign in_y = (py >= ry) && ({1'b0, py} < ({1'b0, ry} + {1'b0, rh}));

  always_ff @(posedge clk) begin
    if (take_write) begin
      rect_store[AW'(cmd.node_index)] <= {cmd.rect_h, cmd.rect_w, cmd.rect_y, cmd.rect_x};
      attr_store[AW'(cmd.node_index)] <= {cmd.can_focus, cmd.z_level};
    end
    if (rd_en) begin
      rd_rect <= rect_store[AW'(scan_cnt)];
      rd_attr <= attr_store[AW'(scan_cnt)];
      rd_idx  <= scan_cnt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_hit <= rd_attr[Z_W] && in_x && in_y;
    cmp_z   <= rd_attr[Z_W-1:0];
    cmp_idx <= rd_idx;
    if (take_query) begin
      px         <= cmd.point_x;
      py         <= cmd.point_y;
      scan_limit <= limit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      cmp_valid <= 1'b0;
      res_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      rd_valid  <= rd_en;
      cmp_valid <= rd_valid;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take_query) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
            found    <= 1'b0;
            best_idx <= '0;
            best_z   <= '0;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          // strict compare keeps the lowest index on equal z
          if (cmp_valid && cmp_hit && (!found || (cmp_z > best_z))) begin
            found    <= 1'b1;
            best_idx <= cmp_idx;
            best_z   <= cmp_z;
          end
          if (scan_done) begin
            state     <= ST_IDLE;
            res_valid <= 1'b1;
            res_found <= found;
            res_node  <= best_idx[OUT_DATA_W-1:0];
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/topmost_rect_hit_test.sv
// top level of the topmost rectangle hit test
//
//  channel   | signals                            | moves
//  ----------+------------------------------------+------------------------------------
//  s_axis    | tvalid tready tdata[127:0] tuser   | one write or query item per transfer
//  m_axis    | tvalid tready tdata[7:0] tuser     | one hit result per query
//  cfg       | valid ready data[8:0]              | active_nodes register write
//
// a query scans the first L entries of the node tables, with
// L = min(active_nodes, MAX_NODES); the single table read port scans one entry a cycle
// a write item is taken, with the back end idle, once it reaches the head of the queue
// reset clears control state and active_nodes; the node tables are not cleared
// input fills the input register and the two-entry queue while a scan runs or a result waits
// a finished result holds on m_axis until its transfer; the next query waits for it
module topmost_rect_hit_test #(
  parameter int MAX_NODES = trht_pkg::MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // node_index[7:0] rect_x[23:8] rect_y[39:24] rect_w[55:40] rect_h[71:56]
  // z_level[87:72] can_focus[88] point_x[104:89] point_y[120:105], rest zero
  input  logic [trht_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // action[0]
  input  logic [trht_pkg::IN_USER_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hit_node[7:0]
  output logic [trht_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // hit_found[0]
  output logic [trht_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [trht_pkg::ACTIVE_NODES_W-1:0]  cfg_data
);
  import trht_pkg::*;

  logic [ACTIVE_NODES_W-1:0] active_nodes;
  logic                    fq_push;
  logic                    fq_ready;
  cmd_t                    fq_cmd;
  logic                    qb_valid;
  logic                    qb_pop;
  cmd_t                    qb_cmd;
  logic                    res_found;

  // register writes must only come while the block is idle; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_nodes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_nodes <= cfg_data;
    end
  end

  trht_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .s_user  (s_axis_tuser),
    .q_push  (fq_push),
    .q_ready (fq_ready),
    .q_cmd   (fq_cmd)
  );

  trht_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_push),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_pop   (qb_pop),
    .out_cmd   (qb_cmd)
  );

  trht_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .active_nodes (active_nodes),
    .cmd_valid    (qb_valid),
    .cmd          (qb_cmd),
    .cmd_pop      (qb_pop),
    .res_valid    (m_axis_tvalid),
    .res_ready    (m_axis_tready),
    .res_found    (res_found),
    .res_node     (m_axis_tdata)
  );

  assign m_axis_tuser = OUT_USER_W'(res_found);

endmodule

>>> design/trht_checker.sv
// port-level checks for the topmost rectangle hit test, bound to the top level
module trht_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [trht_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic [trht_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [trht_pkg::ACTIVE_NODES_W-1:0] cfg_data
);
  import trht_pkg::*;

  logic [ACTIVE_NODES_W-1:0] count_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_seen <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_seen <= cfg_data;
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_miss_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("miss result carries a nonzero node");

  a_hit_inside_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> ({1'b0, m_axis_tdata} < count_seen))
    else $error("hit node outside the scanned range");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind topmost_rect_hit_test trht_checker u_trht_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_data      (cfg_data)
);

>>> tb/topmost_rect_hit_test_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the topmost rectangle hit test: node writes, point queries, counts
module topmost_rect_hit_test_tb;
  import trht_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 7;
  // queued node writes may still be in the back end after the last answer
  localparam int DRAIN_CYCLES = 16;
  // longest scan plus entry, read and answer stages, with margin
  localparam int TAIL_CYCLES  = 300;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 130;
  // entries written by the directed rows, scanned while the rest of the table fills
  localparam int FILL_BASE    = 7;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic                    found;
    logic [NODE_INDEX_W-1:0] node;
  } hit_t;

  // one row of the directed table: an active_nodes write or an item on s_axis
  typedef struct {
    bit                        is_cfg;
    logic [ACTIVE_NODES_W-1:0] count;
    cmd_t                      cmd;
    bit                        typed;
    hit_t                      hit;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  // node_index, rect_x, rect_y, rect_w, rect_h, z_level, can_focus, point_x, point_y, zero fill
  logic [IN_DATA_W-1:0]      s_axis_tdata;
  // action
  logic [IN_USER_W-1:0]      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  // hit_node
  logic [OUT_DATA_W-1:0]     m_axis_tdata;
  // hit_found
  logic [OUT_USER_W-1:0]     m_axis_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [ACTIVE_NODES_W-1:0] cfg_data;

  // shadow of the node table and the count register
  logic [COORD_W-1:0]        node_x [MAX_NODES_DEF];
  logic [COORD_W-1:0]        node_y [MAX_NODES_DEF];
  logic [COORD_W-1:0]        node_w [MAX_NODES_DEF];
  logic [COORD_W-1:0]        node_h [MAX_NODES_DEF];
  logic signed [Z_W-1:0]     node_z [MAX_NODES_DEF];
  bit                        node_focus [MAX_NODES_DEF];
  logic [ACTIVE_NODES_W-1:0] active_nodes_q;

  // answers still owed by the block, oldest first
  hit_t                      hits_pending[$];
  hit_t                      want_hit;

  int                        burst_left;
  int                        fail_count;
  int                        writes_sent;
  int                        queries_sent;
  int                        answers_seen;
  int                        hits_seen;
  int                        count_writes;

  topmost_rect_hit_test #(
    .MAX_NODES(MAX_NODES_DEF)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // topmost focusable node holding the point; half-open ranges, ends summed as int so they do not wrap
  function automatic hit_t topmost_hit(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    hit_t                  h;
    logic signed [Z_W-1:0] best_z;
    int                    limit;
    h      = '0;
    best_z = '0;
    limit  = int'(active_nodes_q);
    if (limit > MAX_NODES_DEF) begin
      limit = MAX_NODES_DEF;
    end
    for (int i = 0; i < limit; i++) begin
      if (node_focus[i] &&
          int'(px) >= int'(node_x[i]) && int'(px) < int'(node_x[i]) + int'(node_w[i]) &&
          int'(py) >= int'(node_y[i]) && int'(py) < int'(node_y[i]) + int'(node_h[i])) begin
        // strict compare keeps the lowest index on equal z
        if (!h.found || node_z[i] > best_z) begin
          h.found = 1'b1;
          h.node  = NODE_INDEX_W'(i);
          best_z  = node_z[i];
        end
      end
    end
    return h;
  endfunction

  function automatic stim_row_t row_cfg(int count);
    stim_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.count  = ACTIVE_NODES_W'(count);
    return r;
  endfunction

  // point fields carry all ones, the block must ignore them on a write
  function automatic stim_row_t row_wr(int idx, int x, int y, int w, int h,
                                       logic signed [Z_W-1:0] z, bit focus);
    stim_row_t r;
    r                = '{default: '0};
    r.cmd.action     = ACT_WRITE;
    r.cmd.node_index = NODE_INDEX_W'(idx);
    r.cmd.rect_x     = COORD_W'(x);
    r.cmd.rect_y     = COORD_W'(y);
    r.cmd.rect_w     = COORD_W'(w);
    r.cmd.rect_h     = COORD_W'(h);
    r.cmd.z_level    = z;
    r.cmd.can_focus  = focus;
    r.cmd.point_x    = '1;
    r.cmd.point_y    = '1;
    return r;
  endfunction

  // entry fields carry all ones, the block must ignore them on a query
  function automatic stim_row_t row_q(int px, int py, bit typed, bit found, int node);
    stim_row_t r;
    r               = '{default: '0};
    r.cmd           = '1;
    r.cmd.action    = ACT_QUERY;
    r.cmd.point_x   = COORD_W'(px);
    r.cmd.point_y   = COORD_W'(py);
    r.typed         = typed;
    r.hit.found     = found;
    r.hit.node      = NODE_INDEX_W'(node);
    return r;
  endfunction

  // node write; half the time aimed below span so it lands in the scanned range
  function automatic cmd_t rand_write(int span);
    cmd_t c;
    int   mode;
    c.action     = ACT_WRITE;
    c.node_index = (span > 0 && $urandom_range(0, 1) == 1) ?
                   NODE_INDEX_W'($urandom_range(0, span - 1)) : NODE_INDEX_W'($urandom);
    // mostly small overlapping rectangles near the origin so queries hit often
    c.rect_x     = COORD_W'($urandom_range(0, 300));
    c.rect_y     = COORD_W'($urandom_range(0, 300));
    c.rect_w     = COORD_W'($urandom_range(0, 150));
    c.rect_h     = COORD_W'($urandom_range(0, 150));
    mode         = $urandom_range(0, 9);
    if (mode == 7) begin
      c.rect_x = COORD_W'($urandom);
      c.rect_y = COORD_W'($urandom);
      c.rect_w = COORD_W'($urandom);
      c.rect_h = COORD_W'($urandom);
    end else if (mode == 8) begin
      // ends past the top of the coordinate range must not wrap
      c.rect_x = COORD_W'($urandom_range(65300, 65535));
      c.rect_y = COORD_W'($urandom_range(65300, 65535));
      c.rect_w = COORD_W'($urandom_range(0, 600));
      c.rect_h = COORD_W'($urandom_range(0, 600));
    end else if (mode == 9) begin
      if ($urandom_range(0, 1) == 1) begin
        c.rect_w = '0;
      end else begin
        c.rect_h = '0;
      end
    end
    // a narrow z spread gives plenty of ties
    c.z_level   = ($urandom_range(0, 9) < 7) ? Z_W'($urandom_range(0, 6)) - Z_W'(3)
                                              : Z_W'($urandom);
    c.can_focus = ($urandom_range(0, 4) != 0);
    c.point_x   = COORD_W'($urandom);
    c.point_y   = COORD_W'($urandom);
    return c;
  endfunction

  function automatic cmd_t rand_query();
    cmd_t c;
    int   mode;
    c.action     = ACT_QUERY;
    c.node_index = NODE_INDEX_W'($urandom);
    c.rect_x     = COORD_W'($urandom);
    c.rect_y     = COORD_W'($urandom);
    c.rect_w     = COORD_W'($urandom);
    c.rect_h     = COORD_W'($urandom);
    c.z_level    = Z_W'($urandom);
    c.can_focus  = 1'($urandom);
    mode         = $urandom_range(0, 9);
    if (mode < 8) begin
      c.point_x = COORD_W'($urandom_range(0, 450));
      c.point_y = COORD_W'($urandom_range(0, 450));
    end else if (mode == 8) begin
      c.point_x = COORD_W'($urandom_range(65200, 65535));
      c.point_y = COORD_W'($urandom_range(65200, 65535));
    end else begin
      c.point_x = COORD_W'($urandom);
      c.point_y = COORD_W'($urandom);
    end
    return c;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // one s_axis transfer; bursts of random length, random gaps between them
  // entered and left at a falling edge, valid stays high inside a burst
  task automatic push_cmd(cmd_t c, bit typed, hit_t typed_hit);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.action;
    s_axis_tdata  = {7'd0, c.point_y, c.point_x, c.can_focus, c.z_level,
                     c.rect_h, c.rect_w, c.rect_y, c.rect_x, c.node_index};
    do @(posedge clk); while (!s_axis_tready);
    // transfer taken: the shadow state moves in item order
    if (c.action == ACT_QUERY) begin
      queries_sent++;
      hits_pending.insert(hits_pending.size(),
                          typed ? typed_hit : topmost_hit(c.point_x, c.point_y));
    end else begin
      writes_sent++;
      node_x[c.node_index]     = c.rect_x;
      node_y[c.node_index]     = c.rect_y;
      node_w[c.node_index]     = c.rect_w;
      node_h[c.node_index]     = c.rect_h;
      node_z[c.node_index]     = c.z_level;
      node_focus[c.node_index] = c.can_focus;
    end
    burst_left--;
    @(negedge clk);
  endtask

  // active_nodes changes only with the block idle
  task automatic write_active_nodes(logic [ACTIVE_NODES_W-1:0] value);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (hits_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    active_nodes_q = value;
    count_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: cycles through always ready, regular, random and long stall patterns
  initial begin
    int tick;
    tick          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      case ((tick / 200) % 4)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = (tick % 4) != 0;
        2:       m_axis_tready = $urandom_range(0, 3) != 0;
        default: m_axis_tready = (tick % 16) >= 10;
      endcase
    end
  end

  // every m_axis transfer is matched against the oldest owed answer
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      answers_seen++;
      if (m_axis_tuser[0]) begin
        hits_seen++;
      end
      if (hits_pending.size() == 0) begin
        note_failure($sformatf("unexpected answer found=%0d node=%0d",
                               m_axis_tuser[0], m_axis_tdata));
      end else begin
        want_hit = hits_pending.pop_front();
        if (m_axis_tuser[0] !== want_hit.found || m_axis_tdata !== want_hit.node) begin
          note_failure($sformatf(
            "answer mismatch: expected found=%0d node=%0d, got found=%0d node=%0d",
            want_hit.found, want_hit.node, m_axis_tuser[0], m_axis_tdata));
        end
      end
    end
  end

  initial begin
    stim_row_t                 dir_rows[$];
    cmd_t                      c;
    logic [ACTIVE_NODES_W-1:0] count;
    int                        span;

    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    burst_left     = 0;
    active_nodes_q = '0;
    fail_count     = 0;
    writes_sent    = 0;
    queries_sent   = 0;
    answers_seen   = 0;
    hits_seen      = 0;
    count_writes   = 0;
    repeat (RST_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed table
    dir_rows.insert(dir_rows.size(), row_cfg(0));
    // nothing scanned after reset
    dir_rows.insert(dir_rows.size(), row_q(0, 0, 1'b1, 1'b0, 0));
    // background over all but the top coordinate in x and y, at the lowest z
    dir_rows.insert(dir_rows.size(), row_wr(0, 0, 0, 65535, 65535, Z_W'(16'h8000), 1'b1));
    // corner node whose ends carry past 16 bits, highest z
    dir_rows.insert(dir_rows.size(),
                    row_wr(1, 65535, 65535, 65535, 65535, Z_W'(16'h7FFF), 1'b1));
    // zero width, then zero height
    dir_rows.insert(dir_rows.size(), row_wr(2, 100, 100, 0, 50, Z_W'(100), 1'b1));
    dir_rows.insert(dir_rows.size(), row_wr(3, 100, 100, 50, 0, Z_W'(200), 1'b1));
    // not focusable, would win on z otherwise
    dir_rows.insert(dir_rows.size(), row_wr(4, 10, 10, 20, 20, Z_W'(16'h7FFF), 1'b0));
    // equal z, lower index wins
    dir_rows.insert(dir_rows.size(), row_wr(5, 10, 10, 20, 20, Z_W'(5), 1'b1));
    dir_rows.insert(dir_rows.size(), row_wr(6, 10, 10, 20, 20, Z_W'(5), 1'b1));
    dir_rows.insert(dir_rows.size(), row_cfg(FILL_BASE));
    dir_rows.insert(dir_rows.size(), row_q(0, 0, 1'b1, 1'b1, 0));
    dir_rows.insert(dir_rows.size(), row_q(65535, 65535, 1'b1, 1'b1, 1));
    // outside the background in y, left of the corner node
    dir_rows.insert(dir_rows.size(), row_q(65534, 65535, 1'b1, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), row_q(100, 120, 1'b0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), row_q(120, 100, 1'b0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), row_q(10, 10, 1'b0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), row_q(29, 29, 1'b0, 1'b0, 0));
    // just outside the half-open square
    dir_rows.insert(dir_rows.size(), row_q(30, 30, 1'b0, 1'b0, 0));
    // drop one tie partner below, the other takes over
    dir_rows.insert(dir_rows.size(), row_wr(5, 10, 10, 20, 20, Z_W'(16'hFFFF), 1'b1));
    dir_rows.insert(dir_rows.size(), row_q(15, 15, 1'b0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), row_cfg(0));
    dir_rows.insert(dir_rows.size(), row_q(10, 10, 1'b1, 1'b0, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_active_nodes(dir_rows[i].count);
      end else begin
        push_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].hit);
      end
    end

    // fill the rest of the table in order, querying the written part meanwhile
    write_active_nodes(ACTIVE_NODES_W'(FILL_BASE));
    for (int n = FILL_BASE; n < MAX_NODES_DEF; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_cmd(rand_query(), 1'b0, '0);
      end
      c            = rand_write(0);
      c.node_index = NODE_INDEX_W'(n);
      push_cmd(c, 1'b0, '0);
    end

    // random phases: full table, counts past the table size, and small counts
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       count = ACTIVE_NODES_W'(256);
        1:       count = ACTIVE_NODES_W'(1);
        2:       count = ACTIVE_NODES_W'(511);
        3:       count = ACTIVE_NODES_W'(2);
        4:       count = ACTIVE_NODES_W'(255);
        5:       count = ACTIVE_NODES_W'(300);
        default: count = ACTIVE_NODES_W'($urandom_range(3, 64));
      endcase
      write_active_nodes(count);
      span = (int'(count) > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(count);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 1) == 1) begin
          push_cmd(rand_query(), 1'b0, '0);
        end else begin
          push_cmd(rand_write(span), 1'b0, '0);
        end
      end
    end

    s_axis_tvalid = 1'b0;
    while (hits_pending.size() != 0) @(negedge clk);
    // any late extra answer shows up in the checker during this pause
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d node writes and %0d point queries over %0d count settings",
             writes_sent, queries_sent, count_writes);
    $display("checked %0d answers, %0d of them hits, %0d failures",
             answers_seen, hits_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #36000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
